FILE: hw/rtl/spp_pkg.sv
// Shared types and constants for the SUBSCRIBE payload parser.
package spp_pkg;

    // Parser phase, one-hot encoded.
    typedef enum logic [5:0] {
        PH_ID_HI  = 6'b000001,
        PH_ID_LO  = 6'b000010,
        PH_LEN_HI = 6'b000100,
        PH_LEN_LO = 6'b001000,
        PH_TOPIC  = 6'b010000,
        PH_QOS    = 6'b100000
    } phase_t;

    // Result classification codes.
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_ID     = 2'd1;
    localparam logic [1:0] KIND_TOPIC  = 2'd2;
    localparam logic [1:0] KIND_QOS    = 2'd3;

    // Truncation error codes.
    localparam logic [2:0] ERR_OK          = 3'd0;
    localparam logic [2:0] ERR_SHORT_ID    = 3'd1;
    localparam logic [2:0] ERR_SHORT_LEN   = 3'd2;
    localparam logic [2:0] ERR_SHORT_TOPIC = 3'd3;
    localparam logic [2:0] ERR_NO_QOS      = 3'd4;

    localparam logic [7:0] TOPIC_COUNT_MAX = 8'hFF;

    // One packet byte as it arrives.
    typedef struct packed {
        logic [7:0] byte_in;
        logic       final_byte;
    } req_t;

    // One classified byte.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] value;
        logic [7:0]  topic_number;
        logic        topic_end;
        logic        packet_done;
        logic [2:0]  error_code;
    } res_t;

    // Parser state carried from byte to byte.
    typedef struct packed {
        phase_t      phase;
        logic [7:0]  high_byte_hold;
        logic [15:0] bytes_left;
        logic [7:0]  topic_count;
    } state_t;

endpackage

FILE: hw/rtl/spp_step.sv
// Per-byte parse logic: classifies one byte and computes the next parser state.
module spp_step (
    input  spp_pkg::state_t cur,
    input  spp_pkg::req_t   req,
    output spp_pkg::state_t nxt,
    output spp_pkg::res_t   res
);

    logic [15:0] assembled;
    logic [15:0] left_dec;

    assign assembled = {cur.high_byte_hold, req.byte_in};
    assign left_dec  = cur.bytes_left - 16'd1;

    // Decode the byte according to the current phase.
    always_comb
    begin
        nxt              = cur;
        res.kind         = spp_pkg::KIND_HEADER;
        res.value        = {8'd0, req.byte_in};
        res.topic_number = cur.topic_count;
        res.topic_end    = 1'b0;
        res.packet_done  = req.final_byte;
        res.error_code   = spp_pkg::ERR_OK;

        case (cur.phase)
            spp_pkg::PH_ID_LO:
            begin
                res.kind         = spp_pkg::KIND_ID;
                res.value        = assembled;
                res.topic_number = 8'd0;
                nxt.phase        = spp_pkg::PH_LEN_HI;
            end
            spp_pkg::PH_LEN_HI:
            begin
                nxt.high_byte_hold = req.byte_in;
                nxt.phase          = spp_pkg::PH_LEN_LO;
                if (req.final_byte)
                    res.error_code = spp_pkg::ERR_SHORT_LEN;
            end
            spp_pkg::PH_LEN_LO:
            begin
                res.value      = assembled;
                nxt.bytes_left = assembled;
                if (assembled == 16'd0)
                begin
                    // An empty topic goes straight to its QoS byte.
                    nxt.phase = spp_pkg::PH_QOS;
                    if (req.final_byte)
                        res.error_code = spp_pkg::ERR_NO_QOS;
                end
                else
                begin
                    nxt.phase = spp_pkg::PH_TOPIC;
                    if (req.final_byte)
                        res.error_code = spp_pkg::ERR_SHORT_TOPIC;
                end
            end
            spp_pkg::PH_TOPIC:
            begin
                res.kind       = spp_pkg::KIND_TOPIC;
                nxt.bytes_left = left_dec;
                if (left_dec == 16'd0)
                begin
                    res.topic_end = 1'b1;
                    nxt.phase     = spp_pkg::PH_QOS;
                    if (req.final_byte)
                        res.error_code = spp_pkg::ERR_NO_QOS;
                end
                else if (req.final_byte)
                begin
                    res.error_code = spp_pkg::ERR_SHORT_TOPIC;
                end
            end
            spp_pkg::PH_QOS:
            begin
                res.kind  = spp_pkg::KIND_QOS;
                nxt.phase = spp_pkg::PH_LEN_HI;
                if (cur.topic_count != spp_pkg::TOPIC_COUNT_MAX)
                    nxt.topic_count = cur.topic_count + 8'd1;
            end
            default:
            begin
                // Identifier high byte, also taken for any unused code.
                res.topic_number   = 8'd0;
                nxt.high_byte_hold = req.byte_in;
                nxt.phase          = spp_pkg::PH_ID_LO;
                if (req.final_byte)
                    res.error_code = spp_pkg::ERR_SHORT_ID;
            end
        endcase

        // The packet's last byte returns the parser to its start.
        if (req.final_byte)
        begin
            nxt.phase          = spp_pkg::PH_ID_HI;
            nxt.high_byte_hold = 8'd0;
            nxt.bytes_left     = 16'd0;
            nxt.topic_count    = 8'd0;
        end
    end

endmodule

FILE: hw/rtl/subscribe_payload_parser_unit.sv
// Top level of the SUBSCRIBE payload parser: input register, parse logic, result register.
//
//   Channel | Handshake            | Payload        | Direction
//   --------+----------------------+----------------+----------
//   request | req_valid, req_stall | req (req_t)    | in
//   result  | res_valid, res_stall | res (res_t)    | out
//
// Every request yields exactly one result; it passes through the input register
// and then the result register. One request is accepted per cycle while req_stall is low;
// the parse state updates as a request moves from the input register to the result register.
// Reset clears the parse state and both valid flags.
// A stall on a full result register holds it and the input register, and raises
// req_stall while the input register holds a request.
module subscribe_payload_parser_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  spp_pkg::req_t   req,
    output logic            res_valid,
    input  logic            res_stall,
    output spp_pkg::res_t   res
);

    logic            s1_valid_reg;
    logic            s1_valid_next;
    spp_pkg::req_t   s1_req_reg;
    logic            res_valid_reg;
    logic            res_valid_next;
    spp_pkg::res_t   res_reg;
    spp_pkg::state_t state_reg;
    spp_pkg::state_t state_next;
    spp_pkg::res_t   step_res;
    logic            advance;

    // The held request moves on when the result register is free or emptying.
    assign advance   = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign req_stall = s1_valid_reg && !advance;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    spp_step u_step (
        .cur (state_reg),
        .req (s1_req_reg),
        .nxt (state_next),
        .res (step_res)
    );

    // Valid flags for the two register stages.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (!req_stall)
            s1_valid_next = req_valid;
        res_valid_next = res_valid_reg;
        if (advance)
            res_valid_next = 1'b1;
        else if (!res_stall)
            res_valid_next = 1'b0;
    end

    // Control state and parse state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg             <= 1'b0;
            res_valid_reg            <= 1'b0;
            state_reg.phase          <= spp_pkg::PH_ID_HI;
            state_reg.high_byte_hold <= 8'd0;
            state_reg.bytes_left     <= 16'd0;
            state_reg.topic_count    <= 8'd0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
            s1_req_reg <= req;
        if (advance)
            res_reg <= step_res;
    end

    // A packet's last byte leaves the parser at its start.
    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_req_reg.final_byte |=> state_reg.phase == spp_pkg::PH_ID_HI)
        else $error("parser not back at start after packet end");

    // Errors are only reported when the packet ends.
    a_err_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.error_code != spp_pkg::ERR_OK |-> res.packet_done)
        else $error("error reported before packet end");

    // Topic end marks only topic bytes.
    a_tend_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.topic_end |-> res.kind == spp_pkg::KIND_TOPIC)
        else $error("topic end on a non-topic byte");

    // The phase register stays one-hot.
    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg.phase))
        else $error("phase register not one-hot");

    // A stalled request is held in the input register, not dropped.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |=> s1_valid_reg)
        else $error("held request lost");

endmodule
